@@ rtl/core/sbr_pkg.sv @@
// Shared constants, codes and types of the spectral band RMS block.
`timescale 1ns / 1ps

package sbr_pkg;

    // Field widths
    localparam int AMP_W      = 16;
    localparam int RMS_W      = 21;
    localparam int SCALED_W   = 37;
    localparam int IDX_W      = 11;
    localparam int SUM_W      = 42;
    localparam int FREQ_W     = 16;
    localparam int PCT_W      = 7;
    localparam int BLK_W      = 12;
    localparam int GAIN_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int EDGE_W     = 24;   // band edge in 1/1600 Hz units
    localparam int MULA_W     = 24;
    localparam int PROD_W     = MULA_W + GAIN_W;
    localparam int NUM_W      = SUM_W; // operand into the iterative unit
    localparam int DIV_W      = 35;   // edge * N
    localparam int DEN_W      = 27;   // 1600 * fs
    localparam int REM_W      = 28;
    localparam int CNT_W      = 6;
    localparam int DIV_STEPS  = DIV_W;
    localparam int SQRT_STEPS = RMS_W;

    // Constants
    localparam int MAX_BLOCK  = 2048;
    localparam int IDX_MAX    = 2047;
    localparam int PCT_FULL   = 100;
    localparam int FS_SCALE   = 1600;
    localparam int CUT_SCALE  = 100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd6;

    // Register reset values
    localparam logic [FREQ_W-1:0] RST_CENTER   = 16'd0;
    localparam logic [PCT_W-1:0]  RST_PERCENT  = 7'd10;
    localparam logic [FREQ_W-1:0] RST_LOW_CUT  = 16'd160;
    localparam logic [FREQ_W-1:0] RST_HIGH_CUT = 16'd12800;
    localparam logic [FREQ_W-1:0] RST_FS       = 16'd1600;
    localparam logic [BLK_W-1:0]  RST_BLOCK    = 12'd1024;
    localparam logic [GAIN_W-1:0] RST_GAIN     = 32'd65536;

    typedef enum logic [3:0] {
        S_EDGE_LO,
        S_EDGE_HI,
        S_NUM_LO,
        S_DLO_GO,
        S_DLO_WAIT,
        S_NUM_HI,
        S_DHI_GO,
        S_DHI_WAIT,
        S_IDLE,
        S_SQ_GO,
        S_SQ_WAIT,
        S_SCALE,
        S_OUT
    } t_state;

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_cmd;

    typedef struct packed {
        logic accept;
        logic clear;
    } t_acc_cmd;

endpackage

@@ rtl/core/sbr_bin_if.sv @@
// Channel carrying spectrum bins into the block.
`timescale 1ns / 1ps

interface sbr_bin_if;
    logic                             valid;
    logic                             ready;
    logic signed [sbr_pkg::AMP_W-1:0] bin_amplitude;
    logic                             last_bin;

    modport source (output valid, bin_amplitude, last_bin, input ready);
    modport sink (input valid, bin_amplitude, last_bin, output ready);
endinterface

@@ rtl/core/sbr_res_if.sv @@
// Channel carrying band RMS results out of the block.
`timescale 1ns / 1ps

interface sbr_res_if;
    logic                            valid;
    logic                            ready;
    logic [sbr_pkg::RMS_W-1:0]       band_rms;
    logic [sbr_pkg::SCALED_W-1:0]    band_rms_scaled;

    modport source (output valid, band_rms, band_rms_scaled, input ready);
    modport sink (input valid, band_rms, band_rms_scaled, output ready);
endinterface

@@ rtl/core/sbr_iter.sv @@
// Shared shift/compare/subtract unit: restoring divide and integer square root.
`timescale 1ns / 1ps

module sbr_iter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbr_pkg::t_iter_cmd          i_cmd,
    input  logic [sbr_pkg::NUM_W-1:0]   i_num,
    input  logic [sbr_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [sbr_pkg::DIV_W-1:0]   o_res
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    sbr_pkg::t_iter_mode          r_mode, n_mode;
    logic [sbr_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [sbr_pkg::NUM_W-1:0]    r_opnd, n_opnd;
    logic [sbr_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [sbr_pkg::DIV_W-1:0]    r_res, n_res;
    logic [sbr_pkg::DEN_W-1:0]    r_den, n_den;

    logic [sbr_pkg::REM_W-1:0]    w_shifted;
    logic [sbr_pkg::REM_W-1:0]    w_trial;
    logic [sbr_pkg::REM_W:0]      w_diff;
    logic                         w_ge;

    // One digit step: bring in the next operand bits and try the subtract
    always_comb begin
        if (r_mode == sbr_pkg::ITER_DIV) begin
            w_shifted = {r_rem[sbr_pkg::REM_W-2:0], r_opnd[sbr_pkg::NUM_W-1]};
            w_trial   = {1'b0, r_den};
        end else begin
            w_shifted = {r_rem[sbr_pkg::REM_W-3:0], r_opnd[sbr_pkg::NUM_W-1 -: 2]};
            w_trial   = {{(sbr_pkg::REM_W - sbr_pkg::RMS_W - 2){1'b0}},
                         r_res[sbr_pkg::RMS_W-1:0], 2'b01};
        end
        w_diff = {1'b0, w_shifted} - {1'b0, w_trial};
        w_ge   = ~w_diff[sbr_pkg::REM_W];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_opnd = r_opnd;
        n_rem  = r_rem;
        n_res  = r_res;
        n_den  = r_den;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_mode = i_cmd.mode;
            n_rem  = '0;
            n_res  = '0;
            n_den  = i_den;
            if (i_cmd.mode == sbr_pkg::ITER_DIV) begin
                n_opnd = i_num << (sbr_pkg::NUM_W - sbr_pkg::DIV_W);
                n_cnt  = sbr_pkg::CNT_W'(sbr_pkg::DIV_STEPS);
            end else begin
                n_opnd = i_num;
                n_cnt  = sbr_pkg::CNT_W'(sbr_pkg::SQRT_STEPS);
            end
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[sbr_pkg::REM_W-1:0] : w_shifted;
            n_res = {r_res[sbr_pkg::DIV_W-2:0], w_ge};
            n_opnd = (r_mode == sbr_pkg::ITER_DIV) ? (r_opnd << 1) : (r_opnd << 2);
            n_cnt = r_cnt - sbr_pkg::CNT_W'(1);
            if (r_cnt == sbr_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= sbr_pkg::ITER_DIV;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd <= n_opnd;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/core/sbr_accum.sv @@
// Bin counter and saturating in-band energy accumulator.
`timescale 1ns / 1ps

module sbr_accum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbr_pkg::t_acc_cmd                 i_cmd,
    input  logic signed [sbr_pkg::AMP_W-1:0]  i_amp,
    input  logic [sbr_pkg::IDX_W-1:0]         i_low_idx,
    input  logic [sbr_pkg::IDX_W-1:0]         i_high_idx,
    output logic [sbr_pkg::SUM_W-1:0]         o_energy
);

    logic [sbr_pkg::IDX_W-1:0]        r_bin_cnt, n_bin_cnt;
    logic [sbr_pkg::SUM_W-1:0]        r_sum, n_sum;

    logic signed [2*sbr_pkg::AMP_W-1:0] w_sq;
    logic [2*sbr_pkg::AMP_W-1:0]        w_term;
    logic [sbr_pkg::SUM_W:0]            w_add;
    logic                               w_in_band;

    assign w_sq      = i_amp * i_amp;
    assign w_term    = {w_sq[2*sbr_pkg::AMP_W-2:0], 1'b0};
    assign w_add     = {1'b0, r_sum} + (sbr_pkg::SUM_W + 1)'(w_term);
    assign w_in_band = (r_bin_cnt >= i_low_idx) && (r_bin_cnt <= i_high_idx);

    always_comb begin
        n_bin_cnt = r_bin_cnt;
        n_sum     = r_sum;
        if (i_cmd.clear) begin
            n_bin_cnt = '0;
            n_sum     = '0;
        end else if (i_cmd.accept) begin
            if (w_in_band) begin
                // saturate at the top of the accumulator
                n_sum = w_add[sbr_pkg::SUM_W] ? '1 : w_add[sbr_pkg::SUM_W-1:0];
            end
            if (r_bin_cnt != sbr_pkg::IDX_W'(sbr_pkg::IDX_MAX)) begin
                n_bin_cnt = r_bin_cnt + sbr_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
            r_sum     <= '0;
        end else begin
            r_bin_cnt <= n_bin_cnt;
            r_sum     <= n_sum;
        end
    end

    assign o_energy = r_sum;

endmodule

@@ rtl/core/spectral_band_rms.sv @@
// Top level of the spectral band RMS block: registers, sequencer and datapath.
//
// Usage: spectrum bins of one real FFT arrive on i_bin in order, bin 0 first,
// with last_bin set on the final bin. Bins inside the band add 2*a^2 to an
// exact 42-bit accumulator, one bin per cycle with no stall. A transfer that
// carries last_bin starts the shared shift/subtract unit on a 21-step square
// root; the result then goes through one multiply by the Q16.16 gain and is
// placed in an output register. i_bin is held not ready from the last bin until
// the result is in the output register. The output register holds band_rms and
// band_rms_scaled until o_res takes the transfer; bins of the next spectrum are
// accepted while it waits, and only a further last bin stalls behind it.
// Band edges are recomputed after reset and after every register write: two
// multiplies per edge and two 35-step divides on the same shared unit, during which
// i_bin is not ready. Configuration writes on i_cfg_* take effect at once and must
// only arrive while the block is idle.
// Reset is synchronous, active low: registers return to their defaults, the
// accumulator and bin counter clear and the band computation starts.
`timescale 1ns / 1ps

module spectral_band_rms (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sbr_bin_if.sink                            i_bin,
    sbr_res_if.source                          o_res
);

    // Configuration registers
    logic [sbr_pkg::FREQ_W-1:0]   r_center;
    logic [sbr_pkg::PCT_W-1:0]    r_pct;
    logic [sbr_pkg::FREQ_W-1:0]   r_low_cut;
    logic [sbr_pkg::FREQ_W-1:0]   r_high_cut;
    logic [sbr_pkg::FREQ_W-1:0]   r_fs;
    logic [sbr_pkg::BLK_W-1:0]    r_blk;
    logic [sbr_pkg::GAIN_W-1:0]   r_gain;

    // Sequencer
    sbr_pkg::t_state              r_state, n_state;

    // Datapath registers
    logic [sbr_pkg::EDGE_W-1:0]   r_lo;
    logic [sbr_pkg::EDGE_W-1:0]   r_hi;
    logic [sbr_pkg::PROD_W-1:0]   r_prod;
    logic [sbr_pkg::IDX_W-1:0]    r_low_idx;
    logic [sbr_pkg::IDX_W-1:0]    r_high_idx;
    logic [sbr_pkg::RMS_W-1:0]    r_rms;

    // Output register
    logic                         r_out_valid;
    logic [sbr_pkg::RMS_W-1:0]    r_out_rms;
    logic [sbr_pkg::SCALED_W-1:0] r_out_scaled;

    // Decoded controls
    logic                         w_in_ready;
    logic                         w_bin_xfer;
    logic                         w_mul_en;
    logic                         w_out_load;
    sbr_pkg::t_iter_cmd           w_iter_cmd;
    sbr_pkg::t_acc_cmd            w_acc_cmd;

    // Datapath wires
    logic [sbr_pkg::BLK_W-1:0]    w_n;
    logic [sbr_pkg::IDX_W-1:0]    w_n_half;
    logic [sbr_pkg::FREQ_W-1:0]   w_fs_eff;
    logic [sbr_pkg::DEN_W-1:0]    w_den;
    logic [sbr_pkg::EDGE_W-1:0]   w_lc;
    logic [sbr_pkg::EDGE_W-1:0]   w_hc;
    logic [sbr_pkg::MULA_W-1:0]   w_mul_a;
    logic [sbr_pkg::GAIN_W-1:0]   w_mul_b;
    logic [sbr_pkg::PROD_W-1:0]   w_prod;
    logic [sbr_pkg::NUM_W-1:0]    w_iter_num;
    logic                         w_iter_done;
    logic [sbr_pkg::DIV_W-1:0]    w_iter_res;
    logic [sbr_pkg::SUM_W-1:0]    w_energy;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes drop silently
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= sbr_pkg::RST_CENTER;
            r_pct      <= sbr_pkg::RST_PERCENT;
            r_low_cut  <= sbr_pkg::RST_LOW_CUT;
            r_high_cut <= sbr_pkg::RST_HIGH_CUT;
            r_fs       <= sbr_pkg::RST_FS;
            r_blk      <= sbr_pkg::RST_BLOCK;
            r_gain     <= sbr_pkg::RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbr_pkg::CFG_CENTER:   r_center   <= i_cfg_data[sbr_pkg::FREQ_W-1:0];
                sbr_pkg::CFG_PERCENT:  r_pct      <= i_cfg_data[sbr_pkg::PCT_W-1:0];
                sbr_pkg::CFG_LOW_CUT:  r_low_cut  <= i_cfg_data[sbr_pkg::FREQ_W-1:0];
                sbr_pkg::CFG_HIGH_CUT: r_high_cut <= i_cfg_data[sbr_pkg::FREQ_W-1:0];
                sbr_pkg::CFG_FS:       r_fs       <= i_cfg_data[sbr_pkg::FREQ_W-1:0];
                sbr_pkg::CFG_BLOCK:    r_blk      <= i_cfg_data[sbr_pkg::BLK_W-1:0];
                sbr_pkg::CFG_GAIN:     r_gain     <= i_cfg_data[sbr_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Derived band quantities
    // ------------------------------------------------------------------
    assign w_n = (r_blk > sbr_pkg::BLK_W'(sbr_pkg::MAX_BLOCK)) ?
                 sbr_pkg::BLK_W'(sbr_pkg::MAX_BLOCK) : r_blk;
    assign w_n_half = w_n[sbr_pkg::BLK_W-1:1];
    assign w_fs_eff = (r_fs == '0) ? sbr_pkg::FREQ_W'(1) : r_fs;
    assign w_den = sbr_pkg::DEN_W'(w_fs_eff) * sbr_pkg::DEN_W'(sbr_pkg::FS_SCALE);
    assign w_lc = sbr_pkg::EDGE_W'(r_low_cut) * sbr_pkg::EDGE_W'(sbr_pkg::CUT_SCALE);
    assign w_hc = sbr_pkg::EDGE_W'(r_high_cut) * sbr_pkg::EDGE_W'(sbr_pkg::CUT_SCALE);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbr_pkg::S_EDGE_LO:  n_state = sbr_pkg::S_EDGE_HI;
            sbr_pkg::S_EDGE_HI:  n_state = sbr_pkg::S_NUM_LO;
            sbr_pkg::S_NUM_LO:   n_state = sbr_pkg::S_DLO_GO;
            sbr_pkg::S_DLO_GO:   n_state = sbr_pkg::S_DLO_WAIT;
            sbr_pkg::S_DLO_WAIT: begin
                if (w_iter_done) n_state = sbr_pkg::S_NUM_HI;
            end
            sbr_pkg::S_NUM_HI:   n_state = sbr_pkg::S_DHI_GO;
            sbr_pkg::S_DHI_GO:   n_state = sbr_pkg::S_DHI_WAIT;
            sbr_pkg::S_DHI_WAIT: begin
                if (w_iter_done) n_state = sbr_pkg::S_IDLE;
            end
            sbr_pkg::S_IDLE: begin
                if (w_bin_xfer && i_bin.last_bin) n_state = sbr_pkg::S_SQ_GO;
            end
            sbr_pkg::S_SQ_GO:    n_state = sbr_pkg::S_SQ_WAIT;
            sbr_pkg::S_SQ_WAIT: begin
                if (w_iter_done) n_state = sbr_pkg::S_SCALE;
            end
            sbr_pkg::S_SCALE:    n_state = sbr_pkg::S_OUT;
            sbr_pkg::S_OUT: begin
                if (!r_out_valid || o_res.ready) n_state = sbr_pkg::S_IDLE;
            end
            default:             n_state = sbr_pkg::S_EDGE_LO;
        endcase
        // any register write restarts the band computation
        if (i_cfg_we) n_state = sbr_pkg::S_EDGE_LO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbr_pkg::S_EDGE_LO;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: decoded controls
    // ------------------------------------------------------------------
    always_comb begin
        w_in_ready       = (r_state == sbr_pkg::S_IDLE) && !i_cfg_we;
        w_bin_xfer       = w_in_ready && i_bin.valid;
        w_iter_cmd.start = (r_state == sbr_pkg::S_DLO_GO) || (r_state == sbr_pkg::S_DHI_GO) ||
                           (r_state == sbr_pkg::S_SQ_GO);
        w_iter_cmd.mode  = (r_state == sbr_pkg::S_SQ_GO) ? sbr_pkg::ITER_SQRT :
                                                           sbr_pkg::ITER_DIV;
        w_acc_cmd.accept = w_bin_xfer;
        w_acc_cmd.clear  = (r_state == sbr_pkg::S_SQ_GO);
        w_out_load       = (r_state == sbr_pkg::S_OUT) && (!r_out_valid || o_res.ready);
        w_mul_en         = 1'b1;
        w_mul_a          = '0;
        w_mul_b          = '0;
        case (r_state)
            sbr_pkg::S_EDGE_LO: begin
                // lower edge: C * (100 - p), nothing below zero
                w_mul_a = sbr_pkg::MULA_W'(r_center);
                w_mul_b = (r_pct > sbr_pkg::PCT_W'(sbr_pkg::PCT_FULL)) ? '0 :
                          sbr_pkg::GAIN_W'(sbr_pkg::PCT_W'(sbr_pkg::PCT_FULL) - r_pct);
            end
            sbr_pkg::S_EDGE_HI: begin
                w_mul_a = sbr_pkg::MULA_W'(r_center);
                w_mul_b = sbr_pkg::GAIN_W'(r_pct) + sbr_pkg::GAIN_W'(sbr_pkg::PCT_FULL);
            end
            sbr_pkg::S_NUM_LO: begin
                w_mul_a = r_lo;
                w_mul_b = sbr_pkg::GAIN_W'(w_n);
            end
            sbr_pkg::S_NUM_HI: begin
                w_mul_a = r_hi;
                w_mul_b = sbr_pkg::GAIN_W'(w_n);
            end
            sbr_pkg::S_SCALE: begin
                w_mul_a = sbr_pkg::MULA_W'(r_rms);
                w_mul_b = r_gain;
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    assign w_prod     = sbr_pkg::PROD_W'(w_mul_a) * sbr_pkg::PROD_W'(w_mul_b);
    assign w_iter_num = (r_state == sbr_pkg::S_SQ_GO) ? w_energy :
                        sbr_pkg::NUM_W'(r_prod[sbr_pkg::DIV_W-1:0]);

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mul_en) r_prod <= w_prod;
        case (r_state)
            sbr_pkg::S_EDGE_HI: begin
                // clamp the lower edge up to the low cutoff
                r_lo <= (r_prod[sbr_pkg::EDGE_W-1:0] <= w_lc) ? w_lc :
                        r_prod[sbr_pkg::EDGE_W-1:0];
            end
            sbr_pkg::S_NUM_LO: begin
                // clamp the upper edge down to the high cutoff
                r_hi <= (r_prod[sbr_pkg::EDGE_W-1:0] >= w_hc) ? w_hc :
                        r_prod[sbr_pkg::EDGE_W-1:0];
            end
            sbr_pkg::S_DLO_WAIT: begin
                if (w_iter_done) begin
                    r_low_idx <= (w_iter_res >= sbr_pkg::DIV_W'(sbr_pkg::IDX_MAX)) ?
                                 sbr_pkg::IDX_W'(sbr_pkg::IDX_MAX) :
                                 w_iter_res[sbr_pkg::IDX_W-1:0] + sbr_pkg::IDX_W'(1);
                end
            end
            sbr_pkg::S_DHI_WAIT: begin
                if (w_iter_done) begin
                    r_high_idx <= (w_iter_res > sbr_pkg::DIV_W'(w_n_half)) ? w_n_half :
                                  w_iter_res[sbr_pkg::IDX_W-1:0];
                end
            end
            sbr_pkg::S_SQ_WAIT: begin
                // an empty band reports one
                if (w_iter_done) begin
                    r_rms <= (w_iter_res[sbr_pkg::RMS_W-1:0] == '0) ? sbr_pkg::RMS_W'(1) :
                             w_iter_res[sbr_pkg::RMS_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_rms    <= r_rms;
            r_out_scaled <= r_prod[16 +: sbr_pkg::SCALED_W];
        end
    end

    assign i_bin.ready           = w_in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.band_rms        = r_out_rms;
    assign o_res.band_rms_scaled = r_out_scaled;

    // ------------------------------------------------------------------
    // Units
    // ------------------------------------------------------------------
    sbr_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_iter_cmd),
        .i_num   (w_iter_num),
        .i_den   (w_den),
        .o_done  (w_iter_done),
        .o_res   (w_iter_res)
    );

    sbr_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_acc_cmd),
        .i_amp      (i_bin.bin_amplitude),
        .i_low_idx  (r_low_idx),
        .i_high_idx (r_high_idx),
        .o_energy   (w_energy)
    );

`ifndef SYNTH
    // the upper band index never passes the middle of the spectrum
    a_high_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbr_pkg::S_IDLE) |-> (r_high_idx <= w_n_half))
        else $error("band upper index beyond N/2");

    // the shared unit finishes only where the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_iter_done |-> (r_state == sbr_pkg::S_DLO_WAIT || r_state == sbr_pkg::S_DHI_WAIT ||
                         r_state == sbr_pkg::S_SQ_WAIT))
        else $error("iterative unit done outside a wait state");

    // a new result appears only out of the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == sbr_pkg::S_OUT))
        else $error("result loaded outside the output state");

    // a delivered root is never zero
    a_rms_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rms != '0))
        else $error("band rms of zero presented");
`endif

endmodule

@@ tb/sbr_band_checker.sv @@
// Band RMS checker: watches the bin and result channels, predicts and compares.
`timescale 1ns / 1ps

module sbr_band_checker
    import sbr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sbr_bin_if                    i_bin,
    sbr_res_if                    i_res,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_results
);

    localparam logic [63:0] SUM_CAP   = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] RMS_CAP   = (64'd1 << RMS_W) - 64'd1;
    localparam int          PRINT_MAX = 50;

    typedef struct packed {
        logic [RMS_W-1:0]    rms;
        logic [SCALED_W-1:0] scaled;
    } t_band_result;

    // Register copies
    logic [FREQ_W-1:0] center_q4;
    logic [PCT_W-1:0]  pct;
    logic [FREQ_W-1:0] low_cut_q4;
    logic [FREQ_W-1:0] high_cut_q4;
    logic [FREQ_W-1:0] fs_hz;
    logic [BLK_W-1:0]  blk_n;
    logic [GAIN_W-1:0] gain_q16;

    // Spectrum state
    logic [IDX_W-1:0]  bin_idx;
    logic [SUM_W-1:0]  energy;
    logic [IDX_W-1:0]  band_lo_idx;
    logic [IDX_W-1:0]  band_hi_idx;

    t_band_result band_result_q[$];

    task automatic report_mismatch(input string what);
        if (o_mismatches < PRINT_MAX)
            $display("MISMATCH at %0t: %s", $time, what);
        o_mismatches++;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Edges in units of 1/1600 Hz, then bin indices, all exact in 64 bits.
    function automatic void refresh_band_edges();
        logic [63:0] n, fs, lo, hi, lc, hc, den, li, ui;
        n   = (blk_n > MAX_BLOCK) ? 64'(MAX_BLOCK) : 64'(blk_n);
        fs  = (fs_hz == '0) ? 64'd1 : 64'(fs_hz);
        lo  = (pct > PCT_FULL) ? 64'd0 : 64'(center_q4) * 64'(PCT_FULL - int'(pct));
        hi  = 64'(center_q4) * 64'(PCT_FULL + int'(pct));
        lc  = 64'(low_cut_q4) * 64'(CUT_SCALE);
        hc  = 64'(high_cut_q4) * 64'(CUT_SCALE);
        den = 64'(FS_SCALE) * fs;
        if (lo <= lc)
            lo = lc;
        if (hi >= hc)
            hi = hc;
        li = lo * n / den + 64'd1;
        ui = hi * n / den;
        if (ui > n / 2)
            ui = n / 2;
        band_lo_idx = (li > 64'(IDX_MAX)) ? IDX_W'(IDX_MAX) : li[IDX_W-1:0];
        band_hi_idx = (ui > 64'(IDX_MAX)) ? IDX_W'(IDX_MAX) : ui[IDX_W-1:0];
    endfunction

    function automatic void load_defaults();
        center_q4   = RST_CENTER;
        pct         = RST_PERCENT;
        low_cut_q4  = RST_LOW_CUT;
        high_cut_q4 = RST_HIGH_CUT;
        fs_hz       = RST_FS;
        blk_n       = RST_BLOCK;
        gain_q16    = RST_GAIN;
        bin_idx     = '0;
        energy      = '0;
        refresh_band_edges();
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0]  idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CENTER:   center_q4   = val[FREQ_W-1:0];
            CFG_PERCENT:  pct         = val[PCT_W-1:0];
            CFG_LOW_CUT:  low_cut_q4  = val[FREQ_W-1:0];
            CFG_HIGH_CUT: high_cut_q4 = val[FREQ_W-1:0];
            CFG_FS:       fs_hz       = val[FREQ_W-1:0];
            CFG_BLOCK:    blk_n       = val[BLK_W-1:0];
            CFG_GAIN:     gain_q16    = val[GAIN_W-1:0];
            default:      return;
        endcase
        refresh_band_edges();
    endfunction

    // Accumulate one bin; on the last bin queue the expected band result.
    function automatic void take_bin(input logic signed [AMP_W-1:0] amp, input logic last);
        logic [63:0]  mag;
        logic [63:0]  sum;
        logic [63:0]  rms;
        t_band_result r;
        mag = (amp < 0) ? 64'(-int'(amp)) : 64'(int'(amp));
        if (bin_idx >= band_lo_idx && bin_idx <= band_hi_idx) begin
            sum    = 64'(energy) + 64'd2 * mag * mag;
            energy = (sum > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : sum[SUM_W-1:0];
        end
        if (bin_idx < IDX_MAX)
            bin_idx++;
        if (!last)
            return;
        rms = floor_sqrt(64'(energy));
        if (rms == 64'd0)
            rms = 64'd1;
        if (rms > RMS_CAP)
            rms = RMS_CAP;
        r.rms    = rms[RMS_W-1:0];
        r.scaled = SCALED_W'((rms * 64'(gain_q16)) >> 16);
        band_result_q.push_back(r);
        bin_idx = '0;
        energy  = '0;
    endfunction

    task automatic check_result();
        t_band_result want;
        o_results++;
        if (band_result_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: rms %0d scaled %0d",
                                      i_res.band_rms, i_res.band_rms_scaled));
            return;
        end
        want = band_result_q.pop_front();
        if (i_res.band_rms !== want.rms)
            report_mismatch($sformatf("band_rms %0d, predicted %0d",
                                      i_res.band_rms, want.rms));
        if (i_res.band_rms_scaled !== want.scaled)
            report_mismatch($sformatf("band_rms_scaled %0d, predicted %0d",
                                      i_res.band_rms_scaled, want.scaled));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_defaults();
            band_result_q.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1)
                check_result();
            if (i_cfg_we === 1'b1)
                apply_cfg(i_cfg_idx, i_cfg_data);
            if (i_bin.valid === 1'b1 && i_bin.ready === 1'b1)
                take_bin(i_bin.bin_amplitude, i_bin.last_bin);
        end
        o_pending = band_result_q.size();
    end

endmodule

@@ tb/tb_spectral_band_rms.sv @@
// Testbench top for the spectral band RMS block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_spectral_band_rms;
    import sbr_pkg::*;

    // Index past the register list; the block must drop such writes.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int     HALF_PERIOD   = 5;
    localparam int     RESET_CYCLES  = 12;
    // Band recompute after a write or reset; hold off until it is done.
    localparam int     SETTLE_CYCLES = 120;
    localparam int     PHASES        = 14;
    localparam int     PHASE_BINS    = 30;
    localparam int     LONG_SPECTRUM = 1040;
    localparam int     HEAVY_PCT     = 64;
    localparam int     LIGHT_PCT     = 18;
    localparam longint TIMEOUT_NS    = 5_000_000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum int {
        PH_TINY,       // N = 2, widest possible centre, zero gain
        PH_SATURATE,   // fs = 0, oversize N, edges past the index range
        PH_SLOW_FS,    // fs = 0 with an odd N and a live band
        PH_FULL_BAND,  // N = 2048, band over bins 1 to N/2, overlong spectrum
        PH_WIDE_PCT,   // percent above 100 drops the low edge to the low cutoff
        PH_RANDOM
    } t_phase_kind;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sbr_bin_if bin_ch ();
    sbr_res_if res_ch ();

    int         mismatches;
    int         pending;
    int         results;
    int         bins_sent     = 0;
    int         settings_used = 0;
    t_idle_mode idle_mode     = IDLE_NONE;
    logic [BLK_W-1:0] cfg_block = RST_BLOCK;

    spectral_band_rms dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_bin      (bin_ch),
        .o_res      (res_ch)
    );

    sbr_band_checker u_band_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_bin        (bin_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Drive channel inputs to known values before the first edge.
    initial begin
        bin_ch.valid         = 1'b0;
        bin_ch.bin_amplitude = '0;
        bin_ch.last_bin      = 1'b0;
        res_ch.ready         = 1'b0;
    end

    // Result side back-pressure: re-roll ready on every falling edge.
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_SNK:  res_ch.ready <= ($urandom_range(99) >= HEAVY_PCT);
            IDLE_BOTH: res_ch.ready <= ($urandom_range(99) >= LIGHT_PCT);
            default:   res_ch.ready <= 1'b1;
        endcase
    end

    // Bins in one well-formed spectrum: 0 .. N/2, with N capped at MAX_BLOCK.
    function automatic int full_len();
        int n_eff;
        n_eff = (cfg_block > MAX_BLOCK) ? MAX_BLOCK : int'(cfg_block);
        return n_eff / 2 + 1;
    endfunction

    // Fill bits above a field with noise; the block must mask them off.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int w, input bit junk);
        if (!junk || w >= CFG_DATA_W)
            return v;
        return v | (CFG_DATA_W'($urandom) << w);
    endfunction

    function automatic logic signed [AMP_W-1:0] pick_amp(input bit loud);
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return loud ? 16'sh8000 : 16'sh0000;
            3:       return loud ? 16'sh8000 : ($urandom_range(1) ? 16'sh0001 : 16'shFFFF);
            default: return loud ? 16'sh8000 : AMP_W'($urandom);
        endcase
    endfunction

    // One register write, then hold off until the band recompute is done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_BLOCK)
            cfg_block = val[BLK_W-1:0];
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [FREQ_W-1:0] c, input logic [PCT_W-1:0] p,
                                 input logic [FREQ_W-1:0] lc, input logic [FREQ_W-1:0] hc,
                                 input logic [FREQ_W-1:0] fs, input logic [BLK_W-1:0] n,
                                 input logic [GAIN_W-1:0] g, input bit junk);
        write_reg(CFG_CENTER,   with_junk(32'(c),  FREQ_W, junk));
        write_reg(CFG_PERCENT,  with_junk(32'(p),  PCT_W,  junk));
        write_reg(CFG_LOW_CUT,  with_junk(32'(lc), FREQ_W, junk));
        write_reg(CFG_HIGH_CUT, with_junk(32'(hc), FREQ_W, junk));
        write_reg(CFG_FS,       with_junk(32'(fs), FREQ_W, junk));
        write_reg(CFG_BLOCK,    with_junk(32'(n),  BLK_W,  junk));
        write_reg(CFG_GAIN,     g);
        write_reg(CFG_UNUSED,   $urandom);
        settings_used++;
    endtask

    // Present one bin and wait for its transfer. Valid gets exactly one
    // assignment per falling edge, so back-to-back bins never glitch it.
    task automatic send_bin(input logic signed [AMP_W-1:0] amp, input logic last);
        int hold_pct;
        hold_pct = (idle_mode == IDLE_SRC)  ? HEAVY_PCT :
                   (idle_mode == IDLE_BOTH) ? LIGHT_PCT : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < hold_pct) begin
            bin_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        bin_ch.valid         <= 1'b1;
        bin_ch.bin_amplitude <= amp;
        bin_ch.last_bin      <= last;
        @(posedge i_clk);
        while (bin_ch.ready !== 1'b1)
            @(posedge i_clk);
        bins_sent++;
    endtask

    task automatic send_spectrum(input int len, input bit loud);
        for (int k = 0; k < len; k++)
            send_bin(pick_amp(loud), k == len - 1);
    endtask

    // Drop valid, let every predicted result arrive, then let the block go idle.
    task automatic drain_results();
        @(negedge i_clk);
        bin_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input t_phase_kind kind);
        logic [FREQ_W-1:0] c, lc, hc, fs;
        logic [PCT_W-1:0]  p;
        logic [BLK_W-1:0]  n;
        logic [GAIN_W-1:0] g;
        longint            f;
        int                sent, len, full;
        // Baseline: centre the band on a real bin so that it covers something.
        n  = BLK_W'($urandom_range(64, 2));
        fs = FREQ_W'($urandom_range(65535, 1));
        f  = longint'($urandom_range(int'(n) / 2)) * longint'(fs) * 16 / longint'(n);
        c  = (f > 65535) ? 16'hFFFF : FREQ_W'(f);
        p  = PCT_W'($urandom_range(127));
        case ($urandom_range(3))
            0:       lc = FREQ_W'($urandom);
            1:       lc = c >> 1;
            default: lc = '0;
        endcase
        hc = ($urandom_range(3) == 0) ? FREQ_W'($urandom) : 16'hFFFF;
        g  = $urandom;
        case (kind)
            PH_TINY: begin
                c = 16'hFFFF; p = 7'd100; lc = '0; hc = 16'hFFFF;
                fs = 16'd1; n = 12'd2; g = '0;
            end
            PH_SATURATE: begin
                c = 16'hFFFF; p = '0; lc = 16'hFFFF; hc = 16'hFFFF;
                fs = '0; n = 12'hFFF; g = 32'hFFFF_FFFF;
            end
            PH_SLOW_FS: begin
                c = FREQ_W'($urandom_range(8)); p = PCT_W'($urandom_range(100));
                lc = '0; hc = 16'hFFFF; fs = '0; n = 12'd63;
            end
            PH_FULL_BAND: begin
                c = 16'd8192; p = 7'd100; lc = '0; hc = 16'hFFFF;
                fs = 16'd2048; n = 12'd2048; g = 32'hFFFF_FFFF;
            end
            PH_WIDE_PCT: p = PCT_W'($urandom_range(127, 101));
            default: ;
        endcase
        apply_setting(c, p, lc, hc, fs, n, g, kind == PH_RANDOM);

        sent = 0;
        if (kind == PH_FULL_BAND) begin
            // Run past bin N/2 so the extra bins fall outside the band.
            send_spectrum(LONG_SPECTRUM, 1'b1);
            sent = LONG_SPECTRUM;
        end
        while (sent < PHASE_BINS) begin
            full = full_len();
            if (kind == PH_SATURATE) begin
                // Oversize N gives 1025-bin spectra; keep these short.
                len = $urandom_range(24, 1);
            end else begin
                case ($urandom_range(9))
                    7:       len = (full > 1) ? $urandom_range(full - 1, 1) : 1;
                    8:       len = full + $urandom_range(8, 1);
                    9:       len = $urandom_range(full + 8, 1);
                    default: len = full;
                endcase
            end
            send_spectrum(len, $urandom_range(3) == 0);
            sent += len;
        end
        drain_results();
    endtask

    initial begin
        logic signed [AMP_W-1:0] probe_amps [9];
        probe_amps = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                       16'sh0001, 16'shFFFF, 16'sh8000, 16'sh7FFF};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // Reset settings: zero centre leaves the band empty, so expect rms 1.
        send_bin(16'sh7FFF, 1'b0);
        send_bin(16'sh8000, 1'b0);
        send_bin(16'sh0000, 1'b1);
        drain_results();

        // N = 16 at 1600 Hz, 400 Hz +/- 50 %: band covers bins 3 to 6.
        apply_setting(16'd6400, 7'd50, 16'd0, 16'hFFFF, 16'd1600, 12'd16,
                      32'hFFFF_FFFF, 1'b0);
        for (int k = 0; k < 9; k++)
            send_bin(probe_amps[k], k == 8);
        drain_results();

        // Percent over 100: low edge drops to zero, band becomes bins 1 to 8.
        write_reg(CFG_PERCENT, 32'd101);
        for (int k = 0; k < 9; k++)
            send_bin(16'sh8000, k == 8);
        drain_results();

        // The phases rotate the idling pattern so gaps hit every stage.
        for (int ph = 0; ph < PHASES; ph++) begin
            @(posedge i_clk);
            idle_mode = t_idle_mode'(ph % 4);
            run_phase((ph < int'(PH_RANDOM)) ? t_phase_kind'(ph) : PH_RANDOM);
        end

        $display("covered %0d bins over %0d register settings: edge amplitudes, empty",
                 bins_sent, settings_used);
        $display("and full bands, fs of zero, odd and oversize N; %0d results checked",
                 results);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d results still pending", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
